// ===== rtl/fvc_pkg.sv =====
// Shared types and constants for the valid-mode FIR correlation unit.
// No dependencies; imported by every module under rtl/.
package fvc_pkg;

  // Field widths of the streaming payload
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned TAP_IDX_W   = 6;
  localparam int unsigned VALUE_W     = 38;
  localparam int unsigned TAP_COUNT_W = 7;

  // Register reset and default sizing
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd8;
  localparam int unsigned DEF_MAX_TAPS = 64;
  localparam int unsigned DEF_ACC_W    = 39;

  // Item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Per-cycle controls broadcast to every cell of the chain
  typedef struct packed {
    logic s_shift;  // sample ring moves one cell up
    logic t_rot;    // tap ring moves one cell down
    logic t_we;     // coefficient write beat
  } cell_ctl_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic idle;
    logic rot_s;
    logic rot_t;
    logic mac_en;
    logic load_out;
  } seq_ctl_t;

endpackage

// ===== rtl/fvc_cell.sv =====
// One cell of the chain: holds one delay-line sample and one tap coefficient.
// Depends on fvc_pkg for widths and the cell control struct.
module fvc_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fvc_pkg::cell_ctl_t                   ctl,
  input  logic [fvc_pkg::TAP_IDX_W-1:0]        tap_index,
  input  logic signed [fvc_pkg::SAMPLE_W-1:0]  coef_value,
  input  logic signed [fvc_pkg::SAMPLE_W-1:0]  s_in,
  input  logic signed [fvc_pkg::SAMPLE_W-1:0]  t_in,
  output logic signed [fvc_pkg::SAMPLE_W-1:0]  s,
  output logic signed [fvc_pkg::SAMPLE_W-1:0]  t
);
  import fvc_pkg::*;

  logic hit;

  // Decode a coefficient write aimed at this cell
  assign hit = (32'(tap_index) == INDEX);

  // Take the sample from the lower neighbor on a shift or rotation
  always_ff @(posedge clk) begin
    if (ctl.s_shift) begin
      s <= s_in;
    end
  end

  // Rotate the tap from the upper neighbor, or load a new coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      t <= '0;
    end else if (ctl.t_rot) begin
      t <= t_in;
    end else if (ctl.t_we && hit) begin
      t <= coef_value;
    end
  end

endmodule

// ===== rtl/fvc_mac.sv =====
// Multiply-accumulate unit fed by the head cells of the sample and tap rings.
// Depends on fvc_pkg for the sample width and default accumulator width.
module fvc_mac #(
  parameter int unsigned ACC_W = fvc_pkg::DEF_ACC_W
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  logic                                 en,
  input  logic signed [fvc_pkg::SAMPLE_W-1:0]  a,
  input  logic signed [fvc_pkg::SAMPLE_W-1:0]  b,
  output logic signed [ACC_W-1:0]              acc
);
  import fvc_pkg::*;

  logic signed [2*SAMPLE_W-1:0] prod;
  logic                         prod_valid;

  // Register the product before it reaches the adder
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= en;
    end
  end

  // Accumulate exactly; the width covers every tap in use
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

// ===== rtl/fvc_seq.sv =====
// Sequencer that walks the sample and tap rings past the MAC for one result.
// Depends on fvc_pkg for the sequencer control struct.
module fvc_seq #(
  parameter int unsigned MAX_TAPS = fvc_pkg::DEF_MAX_TAPS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [$clog2(MAX_TAPS+1)-1:0]      k_in,
  input  logic                               out_free,
  output fvc_pkg::seq_ctl_t                  ctl
);
  import fvc_pkg::*;

  localparam int unsigned KW = $clog2(MAX_TAPS + 1);
  localparam logic [KW-1:0] N_K = KW'(MAX_TAPS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PRE   = 6'b000010,
    S_MAC   = 6'b000100,
    S_POST  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t         state, state_next;
  logic [KW-1:0]  cnt, cnt_next;
  logic [KW-1:0]  k_reg, k_reg_next;

  // Phases: pre-rotate samples so the oldest window entry reaches the head,
  // multiply K pairs, rotate taps home, let the last product land, deliver.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    k_reg_next = k_reg;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        ctl.idle = 1'b1;
        if (start) begin
          state_next = S_PRE;
          cnt_next   = N_K - k_in;
          k_reg_next = k_in;
        end
      end
      S_PRE: begin
        ctl.rot_s = 1'b1;
        if (cnt == '0) begin
          state_next = S_MAC;
          cnt_next   = k_reg - KW'(1);
        end else begin
          cnt_next = cnt - KW'(1);
        end
      end
      S_MAC: begin
        ctl.mac_en = 1'b1;
        ctl.rot_t  = 1'b1;
        ctl.rot_s  = (cnt != '0);
        if (cnt == '0) begin
          if (k_reg == N_K) begin
            state_next = S_DRAIN;
          end else begin
            state_next = S_POST;
            cnt_next   = N_K - k_reg - KW'(1);
          end
        end else begin
          cnt_next = cnt - KW'(1);
        end
      end
      S_POST: begin
        ctl.rot_t = 1'b1;
        if (cnt == '0) begin
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt - KW'(1);
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      k_reg <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k_reg <= k_reg_next;
    end
  end

endmodule

// ===== rtl/fir_valid_correlation_unit.sv =====
// Valid-mode FIR cross-correlation: input item channel, result channel and
// the tap_count register. A load beat (func = 0) writes one tap; a sample beat
// (func = 1) enters the delay line and, once the row holds tap_count (K)
// samples, produces one Q8.30 result; last_in_row ends the row.
// Load beats and samples without a result never raise in_stall. A sample with a
// result keeps in_stall high while the chain rotates: the sample ring turns to
// bring the oldest window sample to the MAC, K pairs are multiplied, the tap
// ring rotates home, and the product pipe drains. The result then waits in
// S_DONE until the output register is free; in_stall falls in the same cycle
// that out_valid rises, and only then can the next item be taken.
// The output register holds a result while the receiver stalls; the next
// item is still taken, and its result waits until the register frees.
// Synchronous reset clears taps to zero, tap_count to 8 and the row count;
// delay-line contents are not cleared and only samples of the row are used.
// Depends on fvc_pkg, fvc_cell, fvc_mac and fvc_seq.
module fir_valid_correlation_unit #(
  parameter int unsigned MAX_TAPS = fvc_pkg::DEF_MAX_TAPS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   func,
  input  logic [fvc_pkg::TAP_IDX_W-1:0]          tap_index,
  input  logic signed [fvc_pkg::SAMPLE_W-1:0]    coef_value,
  input  logic signed [fvc_pkg::SAMPLE_W-1:0]    sample,
  input  logic                                   last_in_row,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [fvc_pkg::VALUE_W-1:0]     value,
  output logic                                   last_of_row,
  input  logic                                   cfg_we,
  input  logic [fvc_pkg::TAP_COUNT_W-1:0]        cfg_wdata
);
  import fvc_pkg::*;

  localparam int unsigned KW    = $clog2(MAX_TAPS + 1);
  localparam int unsigned ACC_W = (33 + $clog2(MAX_TAPS) > VALUE_W) ?
                                  33 + $clog2(MAX_TAPS) : VALUE_W;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic [TAP_COUNT_W-1:0]       tap_count;
  logic [KW-1:0]                fill;
  logic [KW-1:0]                fill_inc;
  logic [KW-1:0]                k_act;
  logic                         emit;
  logic                         in_beat;
  logic                         sample_beat;
  logic                         load_beat;
  logic                         last_hold;
  logic                         out_free;
  seq_ctl_t                     seq_ctl;
  cell_ctl_t                    cell_ctl;
  logic signed [SAMPLE_W-1:0]   s_q [MAX_TAPS];
  logic signed [SAMPLE_W-1:0]   t_q [MAX_TAPS];
  logic signed [SAMPLE_W-1:0]   s_head_in;
  logic signed [ACC_W-1:0]      acc;
  logic signed [VALUE_W-1:0]    sat;

  // Input handshake
  assign in_stall    = !seq_ctl.idle;
  assign in_beat     = in_valid && !in_stall;
  assign sample_beat = in_beat && (func == FUNC_SAMPLE);
  assign load_beat   = in_beat && (func == FUNC_LOAD);
  assign out_free    = !out_valid || !out_stall;

  // Clamp the tap count into 1..MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      k_act = KW'(1);
    end else if (int'(tap_count) > int'(MAX_TAPS)) begin
      k_act = KW'(MAX_TAPS);
    end else begin
      k_act = KW'(tap_count);
    end
  end

  // Row fill count, saturating at the chain length
  assign fill_inc = (fill < KW'(MAX_TAPS)) ? fill + KW'(1) : fill;
  assign emit     = (fill_inc >= k_act);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (sample_beat) begin
      fill <= last_in_row ? '0 : fill_inc;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
    end else if (cfg_we) begin
      tap_count <= cfg_wdata;
    end
  end

  // Hold the row-end flag for the result under way
  always_ff @(posedge clk) begin
    if (sample_beat) begin
      last_hold <= last_in_row;
    end
  end

  // Cell controls: a new sample and a ring rotation use the same path
  assign cell_ctl.s_shift = sample_beat || seq_ctl.rot_s;
  assign cell_ctl.t_rot   = seq_ctl.rot_t;
  assign cell_ctl.t_we    = load_beat;
  assign s_head_in        = sample_beat ? sample : s_q[MAX_TAPS-1];

  // Chain of cells: samples move up, taps move down, both wrap around
  for (genvar j = 0; j < int'(MAX_TAPS); j++) begin : g_cell
    if (j == 0) begin : g_head
      fvc_cell #(.INDEX(j)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (cell_ctl),
        .tap_index  (tap_index),
        .coef_value (coef_value),
        .s_in       (s_head_in),
        .t_in       (t_q[(j + 1) % MAX_TAPS]),
        .s          (s_q[j]),
        .t          (t_q[j])
      );
    end else begin : g_body
      fvc_cell #(.INDEX(j)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (cell_ctl),
        .tap_index  (tap_index),
        .coef_value (coef_value),
        .s_in       (s_q[j-1]),
        .t_in       (t_q[(j + 1) % MAX_TAPS]),
        .s          (s_q[j]),
        .t          (t_q[j])
      );
    end
  end

  fvc_seq #(.MAX_TAPS(MAX_TAPS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (sample_beat && emit),
    .k_in     (k_act),
    .out_free (out_free),
    .ctl      (seq_ctl)
  );

  fvc_mac #(.ACC_W(ACC_W)) u_mac (
    .clk   (clk),
    .rst   (rst),
    .clear (sample_beat),
    .en    (seq_ctl.mac_en),
    .a     (s_q[0]),
    .b     (t_q[0]),
    .acc   (acc)
  );

  // Saturate to the result width
  always_comb begin
    if (acc > SAT_HI) begin
      sat = VALUE_W'(SAT_HI);
    end else if (acc < SAT_LO) begin
      sat = VALUE_W'(SAT_LO);
    end else begin
      sat = VALUE_W'(acc);
    end
  end

  // Output register: hold the beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_ctl.load_out) begin
      value       <= sat;
      last_of_row <= last_hold;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    seq_ctl.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting beat");

  a_busy_after_emit: assert property (@(posedge clk) disable iff (rst)
    (sample_beat && emit) |=> in_stall)
    else $error("input not held off while a result is computed");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= KW'(MAX_TAPS))
    else $error("row fill count beyond chain length");
`endif

endmodule
